// ----- rtl/aes_kx_pkg.sv -----
// ----------------------------------------------------------------------------
// AES key expansion package
// S-box table, key length codes and GF(2^8) helpers for the key schedule.
// ----------------------------------------------------------------------------
package aes_kx_pkg;

  // Key length codes
  localparam logic [1:0] KLEN_128     = 2'd0;
  localparam logic [1:0] KLEN_192     = 2'd1;
  localparam logic [1:0] KLEN_256     = 2'd2;
  localparam logic [1:0] KLEN_INVALID = 2'd3;

  localparam logic [7:0] RCON_INIT = 8'h01;
  localparam logic [7:0] GF_POLY   = 8'h1b;

  localparam int CFG_ADDR_W = 3;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Multiply by x in GF(2^8)
  function automatic logic [7:0] gf_double(input logic [7:0] b);
    gf_double = {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
  endfunction

  // Substitute each byte of a word
  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // InvMixColumns on one column, byte r in bits 8r+7:8r
  function automatic logic [31:0] inv_mix_word(input logic [31:0] w);
    logic [7:0] a  [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      a[i]  = w[8*i +: 8];
      x2[i] = gf_double(a[i]);
      x4[i] = gf_double(x2[i]);
      x8[i] = gf_double(x4[i]);
      m9[i] = x8[i] ^ a[i];
      mb[i] = x8[i] ^ x2[i] ^ a[i];
      md[i] = x8[i] ^ x4[i] ^ a[i];
      me[i] = x8[i] ^ x4[i] ^ x2[i];
    end
    for (int i = 0; i < 4; i++) begin
      r[8*i +: 8] = me[i] ^ mb[(i + 1) % 4] ^ md[(i + 2) % 4] ^ m9[(i + 3) % 4];
    end
    inv_mix_word = r;
  endfunction

endpackage

// ----- rtl/aes_key_expansion.sv -----
// ----------------------------------------------------------------------------
// AES key expansion
// Expands a 128, 192 or 256-bit key into round keys, one per unstalled cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Write key_length_mode (address 0) over the APB-style port while idle:
//   0 = 128-bit key (11 round keys), 1 = 192-bit (13), 2 = 256-bit (15).
//   Code 3 is ignored: the key transaction is taken and produces nothing.
//   Input channel: one transaction carries the whole key in key_part0..3.
//   in_stall is high while a schedule is being generated.
//   Output channel: one transaction per round key, in order, with the
//   encryption key, its equivalent-inverse-cipher counterpart (to be stored
//   at position rounds - round_index) and last_key on the final one.
//   Schedule: the accepted key sets busy_r, then the first round key is
//   registered for the output and the rest follow one per cycle while the
//   output is not stalled. One shared four-byte S-box round makes four schedule
//   words per round key. The next key is taken the cycle after the last round
//   key is produced, while that result may still wait in the output register.
//   A stall on the output holds the result and freezes the schedule.
//   Reset clears the mode to 128-bit and empties both channels.
// ----------------------------------------------------------------------------
module aes_key_expansion
  import aes_kx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // key input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [63:0]           in_key_part0,
  input  logic [63:0]           in_key_part1,
  input  logic [63:0]           in_key_part2,
  input  logic [63:0]           in_key_part3,
  // round key output
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [3:0]            out_round_index,
  output logic [63:0]           out_enc_key_low,
  output logic [63:0]           out_enc_key_high,
  output logic [63:0]           out_dec_key_low,
  output logic [63:0]           out_dec_key_high,
  output logic                  out_last_key
);

  logic [1:0]  mode_r;
  logic [31:0] key_r  [8];
  logic [31:0] hist_r [8];
  logic        busy_r;
  logic [3:0]  round_r;
  logic [2:0]  ph_r;
  logic [7:0]  rcon_r;
  logic        out_valid_r;
  logic [3:0]  out_idx_r;
  logic [31:0] out_rk_r [4];
  logic        out_last_r;
  logic        out_edge_r;

  logic [3:0]  nk_w;
  logic [3:0]  rounds_w;
  logic        cfg_wr;
  logic        accept;
  logic        adv;
  logic        is_key   [4];
  logic [31:0] back_w   [4];
  logic [31:0] p_w      [4];
  logic [31:0] q_w      [4];
  logic [31:0] prev_w;
  logic        has_sub;
  logic        sub_rot;
  logic [1:0]  sub_pos;
  logic        sub_used;
  logic [31:0] sub_in;
  logic [31:0] sub_out;
  logic [3:0]  pos_sum;
  logic [3:0]  ph_sum;
  logic [2:0]  ph_nxt;
  logic [31:0] dec_w [4];

  // Configuration register access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {30'd0, mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= KLEN_128;
    end else if (cfg_wr) begin
      mode_r <= pwdata[1:0];
    end
  end

  // Decode key length
  always_comb begin
    unique case (mode_r)
      KLEN_128: begin
        nk_w     = 4'd4;
        rounds_w = 4'd10;
      end
      KLEN_192: begin
        nk_w     = 4'd6;
        rounds_w = 4'd12;
      end
      KLEN_256: begin
        nk_w     = 4'd8;
        rounds_w = 4'd14;
      end
      default: begin
        nk_w     = 4'd4;
        rounds_w = 4'd10;
      end
    endcase
  end

  // Handshakes
  assign in_stall = busy_r;
  assign accept   = in_valid && !in_stall;
  assign adv      = busy_r && (!out_valid_r || !out_stall);

  // Word taken from nk positions back in the history window
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      unique case (mode_r)
        KLEN_192: back_w[k] = hist_r[2 + k];
        KLEN_256: back_w[k] = hist_r[k];
        default:  back_w[k] = hist_r[4 + k];
      endcase
      is_key[k] = (round_r == 4'd0) || ((round_r == 4'd1) && ((4'd4 + 4'(k)) < nk_w));
    end
  end

  // Locate the single word of this group, if any, that goes through the S-box
  always_comb begin
    has_sub = 1'b0;
    sub_rot = 1'b0;
    sub_pos = 2'd0;
    pos_sum = '0;
    for (int k = 0; k < 4; k++) begin
      pos_sum = {1'b0, ph_r} + 4'(k);
      if ((pos_sum == 4'd0) || (pos_sum == nk_w)) begin
        has_sub = 1'b1;
        sub_rot = 1'b1;
        sub_pos = 2'(k);
      end else if ((mode_r == KLEN_256) && (pos_sum == 4'd4)) begin
        has_sub = 1'b1;
        sub_pos = 2'(k);
      end
    end
    sub_used = has_sub && !is_key[sub_pos];
  end

  // Plain chain, source for the S-box input
  always_comb begin
    prev_w = hist_r[7];
    for (int k = 0; k < 4; k++) begin
      p_w[k] = is_key[k] ? key_r[{round_r[0], 2'(k)}] : (back_w[k] ^ prev_w);
      prev_w = p_w[k];
    end
  end

  // Shared S-box round
  always_comb begin
    sub_in  = (sub_pos == 2'd0) ? hist_r[7] : p_w[sub_pos - 2'd1];
    sub_out = sub_rot ? (sub_word({sub_in[7:0], sub_in[31:8]}) ^ {24'd0, rcon_r})
                      : sub_word(sub_in);
  end

  // Final chain with the substituted word spliced in
  always_comb begin
    q_w[0] = '0;
    for (int k = 0; k < 4; k++) begin
      if (is_key[k]) begin
        q_w[k] = key_r[{round_r[0], 2'(k)}];
      end else if (has_sub && (sub_pos == 2'(k))) begin
        q_w[k] = back_w[k] ^ sub_out;
      end else if (k == 0) begin
        q_w[k] = back_w[k] ^ hist_r[7];
      end else begin
        q_w[k] = back_w[k] ^ q_w[k - 1];
      end
    end
  end

  // Phase of the group start within the nk-word period
  always_comb begin
    ph_sum = {1'b0, ph_r} + 4'd4;
    ph_nxt = (ph_sum >= nk_w) ? 3'(ph_sum - nk_w) : ph_sum[2:0];
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      round_r     <= '0;
      ph_r        <= '0;
      rcon_r      <= RCON_INIT;
      out_valid_r <= 1'b0;
    end else begin
      if (accept && (mode_r != KLEN_INVALID)) begin
        busy_r  <= 1'b1;
        round_r <= '0;
        ph_r    <= '0;
        rcon_r  <= RCON_INIT;
      end else if (adv) begin
        if (round_r == rounds_w) begin
          busy_r  <= 1'b0;
          round_r <= '0;
          ph_r    <= '0;
          rcon_r  <= RCON_INIT;
        end else begin
          round_r <= round_r + 4'd1;
          ph_r    <= ph_nxt;
          if (sub_used && sub_rot) begin
            rcon_r <= gf_double(rcon_r);
          end
        end
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Key capture, history window and output data
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int j = 0; j < 4; j++) begin
        key_r[2*j]     <= (j == 0) ? in_key_part0[31:0]  :
                          (j == 1) ? in_key_part1[31:0]  :
                          (j == 2) ? in_key_part2[31:0]  : in_key_part3[31:0];
        key_r[2*j + 1] <= (j == 0) ? in_key_part0[63:32] :
                          (j == 1) ? in_key_part1[63:32] :
                          (j == 2) ? in_key_part2[63:32] : in_key_part3[63:32];
      end
    end
    if (adv) begin
      for (int j = 0; j < 4; j++) begin
        hist_r[j]     <= hist_r[j + 4];
        hist_r[j + 4] <= q_w[j];
        out_rk_r[j]   <= q_w[j];
      end
      out_idx_r  <= round_r;
      out_last_r <= (round_r == rounds_w);
      out_edge_r <= (round_r == 4'd0) || (round_r == rounds_w);
    end
  end

  // Decryption key for the equivalent inverse cipher
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      dec_w[j] = out_edge_r ? out_rk_r[j] : inv_mix_word(out_rk_r[j]);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_round_index  = out_idx_r;
  assign out_enc_key_low  = {out_rk_r[1], out_rk_r[0]};
  assign out_enc_key_high = {out_rk_r[3], out_rk_r[2]};
  assign out_dec_key_low  = {dec_w[1], dec_w[0]};
  assign out_dec_key_high = {dec_w[3], dec_w[2]};
  assign out_last_key     = out_last_r;

`ifndef SYNTHESIS
  a_round_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (round_r <= rounds_w))
    else $error("round counter past the last round");

  a_last_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (round_r == rounds_w)) |=> (!busy_r && out_valid_r && out_last_r))
    else $error("schedule did not end on its last round key");

  a_start_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (mode_r != KLEN_INVALID)) |=> (busy_r && (round_r == 4'd0)))
    else $error("accepted key did not start a schedule");

  a_first_is_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_idx_r == 4'd0)) |-> out_edge_r)
    else $error("first round key passed through InvMixColumns");
`endif

endmodule

// ----- tb/sv/aes_key_expansion_test.sv -----
// ----------------------------------------------------------------------------
// AES key expansion testbench
// Loads cipher keys of every length into the key schedule block and checks
// each round key transaction (encryption key, equivalent-inverse-cipher key,
// index and last flag) against a schedule computed inside the bench.
// Directed keys come first, then random keys in segments that switch the key
// length between drains, under three sender/receiver idle mixes.
// ----------------------------------------------------------------------------
module aes_key_expansion_test;
  import aes_kx_pkg::*;

  localparam int CLK_HIGH        = 10;
  localparam int CLK_LOW         = 10;
  localparam int RESET_CYCLES    = 6;
  localparam int SETTLE_CYCLES   = 20;
  localparam int RANDOM_SEGMENTS = 12;
  localparam int SEGMENT_KEYS    = 38;
  localparam int INVALID_KEYS    = 3;
  localparam int TIMEOUT_CYCLES  = 400000;

  localparam logic [CFG_ADDR_W-1:0] ADDR_KEY_LENGTH = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED   = CFG_ADDR_W'(4);

  localparam logic [7:0] REDUCE_POLY  = 8'h1b;
  localparam logic [7:0] AFFINE_CONST = 8'h63;
  localparam logic [7:0] RCON_FIRST   = 8'h01;

  // FIPS-197 appendix keys, byte 0 in bits 7:0
  localparam logic [63:0] FIPS128_P0 = 64'ha6d2ae28_16157e2b;
  localparam logic [63:0] FIPS128_P1 = 64'h3c4fcf09_8815f7ab;
  localparam logic [63:0] FIPS192_P0 = 64'h52640eda_f7b0738e;
  localparam logic [63:0] FIPS192_P1 = 64'he5799080_2bf310c8;
  localparam logic [63:0] FIPS192_P2 = 64'h7b6b2c52_d2eaf862;
  localparam logic [63:0] FIPS256_P0 = 64'hbe71ca15_10eb3d60;
  localparam logic [63:0] FIPS256_P1 = 64'h81777d85_f0ae732b;
  localparam logic [63:0] FIPS256_P2 = 64'hd708613b_072c351f;
  localparam logic [63:0] FIPS256_P3 = 64'hf4df1409_a310982d;

  typedef logic [3:0][63:0] cipher_key_t;

  typedef struct packed {
    logic [3:0]  round_index;
    logic [63:0] enc_low;
    logic [63:0] enc_high;
    logic [63:0] dec_low;
    logic [63:0] dec_high;
    logic        last;
  } round_key_t;

  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr    = '0;
  logic [31:0]           pwdata   = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [63:0]           in_key_part0 = '0;
  logic [63:0]           in_key_part1 = '0;
  logic [63:0]           in_key_part2 = '0;
  logic [63:0]           in_key_part3 = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [3:0]            out_round_index;
  logic [63:0]           out_enc_key_low;
  logic [63:0]           out_enc_key_high;
  logic [63:0]           out_dec_key_low;
  logic [63:0]           out_dec_key_high;
  logic                  out_last_key;

  // Bench copy of the key length register and the S-box
  logic [1:0]  key_length = KLEN_128;
  logic [7:0]  sub_table [256];

  cipher_key_t key_queue [$];
  round_key_t  round_keys_due [$];
  int          keys_queued   = 0;
  int          keys_accepted = 0;
  int          mismatches    = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  aes_key_expansion u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_key_part0     (in_key_part0),
    .in_key_part1     (in_key_part1),
    .in_key_part2     (in_key_part2),
    .in_key_part3     (in_key_part3),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_round_index  (out_round_index),
    .out_enc_key_low  (out_enc_key_low),
    .out_enc_key_high (out_enc_key_high),
    .out_dec_key_low  (out_dec_key_low),
    .out_dec_key_high (out_dec_key_high),
    .out_last_key     (out_last_key)
  );

  always begin
    #CLK_HIGH clk = 1'b1;
    #CLK_LOW  clk = 1'b0;
  end

  // ------------------------------------------------------------------
  // GF(2^8) arithmetic and the key schedule
  // ------------------------------------------------------------------
  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? REDUCE_POLY : 8'h00);
  endfunction

  function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] m);
    logic [7:0] acc;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      if (m[k]) acc ^= a;
      a = xtime(a);
    end
    return acc;
  endfunction

  // Walk p through powers of 3 and q through its inverses, then apply the affine map
  function automatic void build_sub_table();
    logic [7:0] p;
    logic [7:0] q;
    logic [7:0] x;
    p = 8'h01;
    q = 8'h01;
    do begin
      p = p ^ xtime(p);
      q = q ^ {q[6:0], 1'b0};
      q = q ^ {q[5:0], 2'b00};
      q = q ^ {q[3:0], 4'h0};
      if (q[7]) q = q ^ 8'h09;
      x = q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]} ^ {q[3:0], q[7:4]};
      sub_table[p] = x ^ AFFINE_CONST;
    end while (p != 8'h01);
    sub_table[0] = AFFINE_CONST;
  endfunction

  function automatic logic [31:0] substitute(input logic [31:0] w);
    return {sub_table[w[31:24]], sub_table[w[23:16]], sub_table[w[15:8]], sub_table[w[7:0]]};
  endfunction

  function automatic logic [31:0] unmix_column(input logic [31:0] col);
    logic [7:0]  b [4];
    logic [31:0] res;
    for (int i = 0; i < 4; i++) b[i] = col[8*i +: 8];
    for (int i = 0; i < 4; i++) begin
      res[8*i +: 8] = gf_product(b[i], 8'h0e) ^ gf_product(b[(i + 1) % 4], 8'h0b)
                    ^ gf_product(b[(i + 2) % 4], 8'h0d) ^ gf_product(b[(i + 3) % 4], 8'h09);
    end
    return res;
  endfunction

  // Queue every round key that one accepted cipher key should produce
  function automatic void expand_key(input cipher_key_t key);
    logic [31:0] words [60];
    logic [31:0] t;
    logic [7:0]  rcon;
    round_key_t  rk;
    int          nk;
    int          rounds;
    if (key_length == KLEN_INVALID) return;
    nk     = 4 + 2 * int'(key_length);
    rounds = 10 + 2 * int'(key_length);
    rcon   = RCON_FIRST;
    for (int i = 0; i < 4 * (rounds + 1); i++) begin
      if (i < nk) begin
        words[i] = key[i / 2][32 * (i % 2) +: 32];
      end else begin
        t = words[i - 1];
        if (i % nk == 0) begin
          t    = substitute({t[7:0], t[31:8]}) ^ {24'h0, rcon};
          rcon = xtime(rcon);
        end else if (nk == 8 && i % nk == 4) begin
          t = substitute(t);
        end
        words[i] = words[i - nk] ^ t;
      end
    end
    for (int r = 0; r <= rounds; r++) begin
      rk.round_index = 4'(r);
      rk.enc_low     = {words[4*r + 1], words[4*r]};
      rk.enc_high    = {words[4*r + 3], words[4*r + 2]};
      // first and last keys pass unchanged into the inverse schedule
      if (r == 0 || r == rounds) begin
        rk.dec_low  = rk.enc_low;
        rk.dec_high = rk.enc_high;
      end else begin
        rk.dec_low  = {unmix_column(words[4*r + 1]), unmix_column(words[4*r])};
        rk.dec_high = {unmix_column(words[4*r + 3]), unmix_column(words[4*r + 2])};
      end
      rk.last = (r == rounds);
      round_keys_due.push_back(rk);
    end
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endfunction

  // ------------------------------------------------------------------
  // Key driver: present queued keys, hold while stalled
  // ------------------------------------------------------------------
  always @(posedge clk) begin : key_driver
    cipher_key_t next_key;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expand_key({in_key_part3, in_key_part2, in_key_part1, in_key_part0});
        keys_accepted++;
      end
      // load the next key only when no transaction is held
      if (!in_valid || !in_stall) begin
        if (key_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_key     = key_queue.pop_front();
          in_valid     <= 1'b1;
          in_key_part0 <= next_key[0];
          in_key_part1 <= next_key[1];
          in_key_part2 <= next_key[2];
          in_key_part3 <= next_key[3];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Round key monitor: compare each transaction, stall at random
  // ------------------------------------------------------------------
  always @(posedge clk) begin : round_key_monitor
    round_key_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (round_keys_due.size() == 0) begin
          $error("round key %0d arrived with none expected", out_round_index);
          mismatches++;
        end else begin
          want = round_keys_due.pop_front();
          check_field("round_index",  64'(want.round_index), 64'(out_round_index));
          check_field("enc_key_low",  want.enc_low,  out_enc_key_low);
          check_field("enc_key_high", want.enc_high, out_enc_key_high);
          check_field("dec_key_low",  want.dec_low,  out_dec_key_low);
          check_field("dec_key_high", want.dec_high, out_dec_key_high);
          check_field("last_key",     64'(want.last), 64'(out_last_key));
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // ------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_KEY_LENGTH) key_length = data[1:0];
  endtask

  task automatic push_key(input cipher_key_t key);
    key_queue.push_back(key);
    keys_queued++;
  endtask

  function automatic logic [63:0] random_part();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic push_random_keys(input int count);
    for (int n = 0; n < count; n++)
      push_key({random_part(), random_part(), random_part(), random_part()});
  endtask

  // Wait until every key is taken and every round key seen, then let the block settle
  task automatic wait_drained();
    while (keys_accepted != keys_queued || round_keys_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [1:0] code;
    build_sub_table();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 12;
    recv_idle_pct = 48;

    // 128-bit keys at the reset length
    push_key({64'h0, 64'h0, FIPS128_P1, FIPS128_P0});
    push_key('0);
    push_key('1);
    wait_drained();

    // 192-bit, with junk above the mode bits
    write_reg(ADDR_KEY_LENGTH, {30'h3fff_ffff, KLEN_192});
    push_key({64'hffff_ffff_ffff_ffff, FIPS192_P2, FIPS192_P1, FIPS192_P0});
    push_key('0);
    push_key({4{64'haaaa_aaaa_aaaa_aaaa}});
    wait_drained();

    // 256-bit
    write_reg(ADDR_KEY_LENGTH, {30'h1555_5555, KLEN_256});
    push_key({FIPS256_P3, FIPS256_P2, FIPS256_P1, FIPS256_P0});
    push_key('1);
    push_key({4{64'h5555_5555_5555_5555}});
    wait_drained();

    // write past the register list: length must stay 256-bit
    write_reg(ADDR_UNMAPPED, {30'h0, KLEN_128});
    push_random_keys(1);
    wait_drained();

    // undefined length: keys are swallowed
    write_reg(ADDR_KEY_LENGTH, {30'h0, KLEN_INVALID});
    push_random_keys(2);
    wait_drained();
    write_reg(ADDR_KEY_LENGTH, {30'h3fff_ffff, KLEN_128});
    push_random_keys(2);
    wait_drained();

    // random segments, one key length each, three idle mixes
    for (int s = 0; s < RANDOM_SEGMENTS; s++) begin
      case (s / 4)
        0: begin
          send_idle_pct = 12;
          recv_idle_pct = 48;
        end
        1: begin
          send_idle_pct = 48;
          recv_idle_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (s % 5 == 4) begin
        write_reg(ADDR_KEY_LENGTH, {30'($urandom), KLEN_INVALID});
        push_random_keys(INVALID_KEYS);
        wait_drained();
      end
      if ($urandom_range(2) == 0) write_reg(ADDR_UNMAPPED, $urandom);
      code = 2'(s % 3);
      write_reg(ADDR_KEY_LENGTH, {30'($urandom), code});
      push_random_keys(SEGMENT_KEYS);
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hard stop if the handshakes hang
  initial begin : watchdog
    #((CLK_HIGH + CLK_LOW) * TIMEOUT_CYCLES);
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/aes_kx_pkg.sv
rtl/aes_key_expansion.sv
tb/sv/aes_key_expansion_test.sv
